>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the fractional baud calculator.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define UFBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufbc assertion failed");

// Check a consequent in the cycle after its antecedent.
`define UFBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufbc assertion failed");

`endif

>>> rtl/ufbc_pkg.sv
// Package of the fractional baud calculator: widths, constants, payload types,
// status codes and the sequencer states. Depends on nothing.
package ufbc_pkg;

    localparam int CLOCK_W   = 27;
    localparam int BAUD_W    = 32;
    localparam int EXP_W     = 4;
    localparam int DIVISOR_W = 12;
    // A rate inside the window is at most clock/16, so it fits below 2^23.
    localparam int BAUD_OK_W = CLOCK_W - 4;
    localparam int BAUD2_W   = BAUD_OK_W + 1;
    localparam int CALC_W    = 32;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd32000000;
    localparam int MAX_SHIFT = 4;
    localparam int MIN_SHIFT = 23;
    localparam logic [7:0] LIMIT_START = 8'd255;

    localparam logic signed [EXP_W-1:0] EXP_MIN      = -4'sd7;
    localparam logic signed [EXP_W-1:0] EXP_MAX      = 4'sd7;
    localparam logic signed [EXP_W-1:0] EXP_OR_BELOW = -4'sd3;
    localparam logic signed [EXP_W-1:0] EXP_INVALID  = -4'sd8;

    // Quotient bits produced by the serial divider; every quotient stays below 2^17.
    localparam int DIV_STEPS = 18;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [BAUD_W-1:0] requested_baud;
    } ufbc_req_t;

    typedef struct packed {
        logic                        status;
        logic signed [EXP_W-1:0]     scale_exp;
        logic [DIVISOR_W-1:0]        divisor;
    } ufbc_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ufbc_unit_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINISH
    } ufbc_state_t;

endpackage

>>> rtl/ufbc_if.sv
// Valid/ready channel interfaces for requests and results of the baud calculator.
// Depends on ufbc_pkg for the payload types.
interface ufbc_req_if;
    logic                 valid;
    logic                 ready;
    ufbc_pkg::ufbc_req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ufbc_res_if;
    logic                 valid;
    logic                 ready;
    ufbc_pkg::ufbc_res_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ufbc_search.sv
// Scale exponent search: one limit step per cycle, with the limit kept
// premultiplied by the doubled rate so no quotient is needed. Depends on ufbc_pkg.
module ufbc_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ufbc_pkg::BAUD2_W-1:0]         baud2,
    input  logic [ufbc_pkg::CLOCK_W-1:0]         clock_hz,
    output ufbc_pkg::ufbc_unit_stat_t            stat,
    output logic signed [ufbc_pkg::EXP_W-1:0]    exp
);

    logic                                 busy_reg, busy_next;
    logic signed [ufbc_pkg::EXP_W-1:0]    e_reg, e_next;
    logic [ufbc_pkg::CALC_W-1:0]          p_reg, p_next;
    logic [ufbc_pkg::BAUD2_W-1:0]         baud2_reg, baud2_next;
    logic                                 hit;

    // ratio < limit holds exactly when clock < limit * (2 * rate)
    assign hit = (ufbc_pkg::CALC_W'(clock_hz) < p_reg) || (e_reg == ufbc_pkg::EXP_MAX);

    always_comb
    begin
        busy_next  = busy_reg;
        e_next     = e_reg;
        p_next     = p_reg;
        baud2_next = baud2_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            e_next     = ufbc_pkg::EXP_MIN;
            baud2_next = baud2;
            p_next     = ufbc_pkg::CALC_W'(ufbc_pkg::CALC_W'(baud2)
                         * ufbc_pkg::CALC_W'(ufbc_pkg::LIMIT_START));
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                e_next = e_reg + 4'sd1;
                // Low exponents turn the limit L into 2L+1, the rest into 2L.
                if (e_reg < ufbc_pkg::EXP_OR_BELOW)
                begin
                    p_next = (p_reg << 1) + ufbc_pkg::CALC_W'(baud2_reg);
                end
                else
                begin
                    p_next = p_reg << 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        p_reg     <= p_next;
        baud2_reg <= baud2_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && hit;
    assign exp       = e_reg;

endmodule

>>> rtl/ufbc_div.sv
// Restoring divider, one quotient bit per cycle through a shift register.
// Depends on ufbc_pkg for widths and the step count.
module ufbc_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [ufbc_pkg::CALC_W-1:0]           num,
    input  logic [ufbc_pkg::CALC_W-1:0]           den,
    output ufbc_pkg::ufbc_unit_stat_t             stat,
    output logic [ufbc_pkg::DIV_STEPS-1:0]        quot
);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [ufbc_pkg::DIV_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ufbc_pkg::CALC_W-1:0]           rem_reg, rem_next;
    logic [ufbc_pkg::DIV_STEPS-1:0]        q_reg, q_next;
    logic [ufbc_pkg::CALC_W:0]             trial;
    logic                                  fits;

    assign trial = {rem_reg, q_reg[ufbc_pkg::DIV_STEPS-1]};
    assign fits  = trial >= {1'b0, den};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ufbc_pkg::DIV_CNT_W'(ufbc_pkg::DIV_STEPS - 1);
            // The high part stays below the divisor because the quotient is short.
            rem_next  = num >> ufbc_pkg::DIV_STEPS;
            q_next    = num[ufbc_pkg::DIV_STEPS-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? ufbc_pkg::CALC_W'(trial - {1'b0, den})
                            : ufbc_pkg::CALC_W'(trial);
            q_next   = {q_reg[ufbc_pkg::DIV_STEPS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    // The done pulse moves the sequencer out of its DIVIDE state.
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

>>> rtl/usart_fractional_baud_calc.sv
// Channel   Dir   Payload                               Transaction
// req       in    requested_baud[31:0]                  valid & ready
// res       out   status, scale_exp[3:0], divisor[11:0] valid & ready
// cfg       in    cfg_wr_data[26:0] (clock_hz)          cfg_wr_en
//
// An in-range request passes from accept to result through the exponent search
// (one limit per cycle), the serial divider (18 quotient bits, one per cycle,
// then its done flag) and the load of the output register. An out-of-range
// request skips the search and the divider and goes straight to that load.
// rst_n clears control state and restores clock_hz to 32 MHz; req is stalled
// while a request is in work, and a finished result waits in the output register.
//
// Top level of the fractional baud calculator. Depends on ufbc_pkg, ufbc_if,
// ufbc_search, ufbc_div and assert_macros.svh.
`include "assert_macros.svh"

module usart_fractional_baud_calc (
    input  logic                             clk,
    input  logic                             rst_n,
    ufbc_req_if.sink                         req,
    ufbc_res_if.source                       res,
    input  logic                             cfg_wr_en,
    input  logic [ufbc_pkg::CLOCK_W-1:0]     cfg_wr_data
);

    ufbc_pkg::ufbc_state_t                 state_reg, state_next;
    logic [ufbc_pkg::CLOCK_W-1:0]          clock_hz_reg;
    logic [ufbc_pkg::BAUD_OK_W-1:0]        baud_reg;
    logic                                  pend_status_reg;
    logic signed [ufbc_pkg::EXP_W-1:0]     pend_exp_reg;
    logic [ufbc_pkg::DIVISOR_W-1:0]        pend_div_reg;
    logic                                  res_valid_reg, res_valid_next;
    ufbc_pkg::ufbc_res_t                   res_data_reg;

    logic                                  accept;
    logic                                  in_range;
    logic                                  load_out;
    logic                                  search_start;
    logic [ufbc_pkg::BAUD2_W-1:0]          baud2_in;
    ufbc_pkg::ufbc_unit_stat_t             search_stat;
    ufbc_pkg::ufbc_unit_stat_t             div_stat;
    logic signed [ufbc_pkg::EXP_W-1:0]     search_exp;
    logic [ufbc_pkg::DIV_STEPS-1:0]        quot;

    logic signed [ufbc_pkg::EXP_W:0]       k5;
    logic [ufbc_pkg::EXP_W:0]              neg_k5;
    logic [ufbc_pkg::EXP_W-1:0]            sh_up;
    logic [ufbc_pkg::EXP_W-1:0]            sh_dn;
    logic [ufbc_pkg::CALC_W-1:0]           baud_w;
    logic [ufbc_pkg::CALC_W-1:0]           baud2_w;
    logic [ufbc_pkg::CALC_W-1:0]           clk_w;
    logic [ufbc_pkg::CALC_W-1:0]           clk_less;
    logic [ufbc_pkg::CALC_W-1:0]           num;
    logic [ufbc_pkg::CALC_W-1:0]           den;
    logic [ufbc_pkg::DIVISOR_W-1:0]        div_adj;

    // Window: 1 <= rate, clock>>23 <= rate <= clock>>4
    assign in_range = (req.data.requested_baud
                        <= ufbc_pkg::BAUD_W'(clock_hz_reg >> ufbc_pkg::MAX_SHIFT))
                   && (req.data.requested_baud
                        >= ufbc_pkg::BAUD_W'(clock_hz_reg >> ufbc_pkg::MIN_SHIFT))
                   && (req.data.requested_baud != '0);

    assign req.ready    = (state_reg == ufbc_pkg::ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign search_start = accept && in_range;
    assign baud2_in     = {req.data.requested_baud[ufbc_pkg::BAUD_OK_W-1:0], 1'b0};
    assign load_out     = (state_reg == ufbc_pkg::ST_FINISH) && (!res_valid_reg || res.ready);

    ufbc_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (search_start),
        .baud2    (baud2_in),
        .clock_hz (clock_hz_reg),
        .stat     (search_stat),
        .exp      (search_exp)
    );

    // Divider operands: k = exp + 3 sets the shift of either the remainder or the rate.
    assign k5      = {search_exp[ufbc_pkg::EXP_W-1], search_exp} + 5'sd3;
    assign neg_k5  = 5'd0 - k5;
    assign sh_up   = k5[ufbc_pkg::EXP_W-1:0];
    assign sh_dn   = neg_k5[ufbc_pkg::EXP_W-1:0];
    assign baud_w  = ufbc_pkg::CALC_W'(baud_reg);
    assign baud2_w = {baud_w[ufbc_pkg::CALC_W-2:0], 1'b0};
    assign clk_w   = ufbc_pkg::CALC_W'(clock_hz_reg);
    assign clk_less = clk_w - (baud2_w << 3);

    always_comb
    begin
        if (search_exp[ufbc_pkg::EXP_W-1])
        begin
            if (k5[ufbc_pkg::EXP_W] || (k5 == 5'sd0))
            begin
                num = (clk_less << sh_dn) + baud_w;
                den = baud2_w;
            end
            else
            begin
                num = clk_less + (baud_w << sh_up);
                den = baud2_w << sh_up;
            end
        end
        else
        begin
            num = clk_w + (baud_w << sh_up);
            den = baud2_w << sh_up;
        end
    end

    ufbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (search_stat.done),
        .num   (num),
        .den   (den),
        .stat  (div_stat),
        .quot  (quot)
    );

    // Drop one from the divisor for non-negative exponents.
    assign div_adj = quot[ufbc_pkg::DIVISOR_W-1:0]
                   - ufbc_pkg::DIVISOR_W'(!pend_exp_reg[ufbc_pkg::EXP_W-1]);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        case (state_reg)
            ufbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ufbc_pkg::ST_SEARCH : ufbc_pkg::ST_FINISH;
                end
            end
            ufbc_pkg::ST_SEARCH:
            begin
                if (search_stat.done)
                begin
                    state_next = ufbc_pkg::ST_DIVIDE;
                end
            end
            ufbc_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ufbc_pkg::ST_FINISH;
                end
            end
            ufbc_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ufbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ufbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ufbc_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            clock_hz_reg  <= ufbc_pkg::CLOCK_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                clock_hz_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            baud_reg        <= req.data.requested_baud[ufbc_pkg::BAUD_OK_W-1:0];
            pend_status_reg <= in_range ? ufbc_pkg::STATUS_OK : ufbc_pkg::STATUS_RANGE;
            pend_exp_reg    <= '0;
            pend_div_reg    <= '0;
        end
        if (search_stat.done)
        begin
            pend_exp_reg <= search_exp;
        end
        if (div_stat.done)
        begin
            pend_div_reg <= div_adj;
        end
        if (load_out)
        begin
            res_data_reg.status    <= pend_status_reg;
            res_data_reg.scale_exp <= pend_exp_reg;
            res_data_reg.divisor   <= pend_div_reg;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    `UFBC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n,
        req.valid && req.ready, state_reg != ufbc_pkg::ST_IDLE)
    `UFBC_ASSERT_SAME(a_div_done_in_divide, clk, rst_n,
        div_stat.done, state_reg == ufbc_pkg::ST_DIVIDE && !search_stat.busy)
    `UFBC_ASSERT_SAME(a_range_result_zero, clk, rst_n,
        res.valid && res.data.status == ufbc_pkg::STATUS_RANGE,
        res.data.scale_exp == '0 && res.data.divisor == '0)
    `UFBC_ASSERT_SAME(a_exp_in_span, clk, rst_n,
        res.valid, res.data.scale_exp != ufbc_pkg::EXP_INVALID)

endmodule
